>>> rtl/core/sha_pkg.sv
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } beat_t;

  typedef logic [31:0] word_t;

  localparam word_t [7:0] InitH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(logic [5:0] i);
    case (i)
      6'd0: round_k = 32'h428a2f98; 6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf; 6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b; 6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4; 6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98; 6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

>>> rtl/core/sha256_stream_hasher.sv
// channel | valid        | stall        | payload
// in      | in_valid_i   | in_stall_o   | data_byte_i, byte_present_i, end_of_message_i
// out     | out_valid_o  | out_stall_i  | digest_word_o, word_number_o, last_word_o
// a beat with a byte is taken in StIdle; a full block then runs 64 rounds and one add
// an end beat adds one or two padding blocks, then 8 output beats
// the input queue of QueueDepth beats keeps taking bytes while rounds run, until it is full
// reset empties the queue, loads the initial hash words and clears the byte count; no clearing pass
// out_stall_i holds the current digest word until taken
module sha256_stream_hasher import sha_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);

  beat_t in_beat, q_beat;
  logic  full, empty, pop;

  assign in_beat    = '{data: data_byte_i, has_byte: byte_present_i,
                        last: end_of_message_i};
  assign in_stall_o = full;

  sha_fifo #(.Depth(Depth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && !full), .push_data_i(in_beat), .full_o(full),
    .pop_i(pop), .pop_data_o(q_beat), .empty_o(empty)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .beat_valid_i(!empty), .beat_i(q_beat), .beat_pop_o(pop),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_number_o, .last_word_o
  );

endmodule

>>> rtl/core/sha_fifo.sv
module sha_fifo import sha_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  beat_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output beat_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  beat_t            mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [AddrW:0]   cnt_q;

  assign full_o     = (cnt_q == (AddrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AddrW+1)'(push_i) - (AddrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AddrW+1)'(Depth)) else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/sha_core.sv
module sha_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_valid_i,
  input  beat_t       beat_i,
  output logic        beat_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    StIdle, StPad, StRound, StAdd, StEmit
  } state_e;

  state_e      state_q;
  word_t [7:0] h_q;
  word_t [7:0] v_q;
  word_t [15:0] w_q;
  logic [63:0] total_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic        final_q;
  logic        lenblk_q;
  logic [2:0]  idx_q;

  word_t s0, s1, wnext, t1, t2, ch, mj, wcur;
  word_t [15:0] wpad;
  logic [63:0] bits;

  always_comb begin
    wcur  = w_q[0];
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnext = s1 + w_q[9] + s0 + w_q[0];
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ch + round_k(rnd_q) + wcur;
    t2    = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) + mj;
  end

  // padding and length block built combinationally from the shift line
  always_comb begin
    bits = total_q << 3;
    wpad = w_q;
    if (!lenblk_q) begin
      wpad[fill_q[5:2]] = w_q[fill_q[5:2]] | (32'h80 << (8 * (3 - fill_q[1:0])));
    end
    if (lenblk_q || fill_q < 6'd56) begin
      wpad[14] = bits[63:32];
      wpad[15] = bits[31:0];
    end
  end

  assign beat_pop_o    = (state_q == StIdle) && beat_valid_i;
  assign out_valid_o   = (state_q == StEmit);
  assign digest_word_o = h_q[idx_q];
  assign word_number_o = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      h_q      <= InitH;
      total_q  <= '0;
      fill_q   <= '0;
      rnd_q    <= '0;
      final_q  <= 1'b0;
      lenblk_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (beat_valid_i) begin
            final_q <= beat_i.last;
            if (beat_i.has_byte) begin
              if (fill_q[1:0] == 2'd0) begin
                w_q[fill_q[5:2]] <= {beat_i.data, 24'h0};
              end else begin
                w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= beat_i.data;
              end
              total_q <= total_q + 64'd1;
              fill_q  <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                state_q <= StRound;
                v_q     <= h_q;
                rnd_q   <= '0;
                final_q <= 1'b0;
                lenblk_q <= 1'b0;
                if (beat_i.last) state_q <= StRound;
              end else if (beat_i.last) begin
                state_q <= StPad;
              end
              if (fill_q == 6'd63 && beat_i.last) final_q <= 1'b1;
            end else if (beat_i.last) begin
              state_q <= StPad;
            end
          end
        end
        StPad: begin
          // clear bytes past the marker, then place marker and length
          for (int i = 0; i < 16; i++) begin
            if (!lenblk_q) begin
              if (6'(4 * i) >= fill_q) w_q[i] <= '0;
              else if (6'(4 * i + 3) >= fill_q)
                w_q[i] <= w_q[i] & ~(32'hffffffff >> (8 * (fill_q - 6'(4 * i))));
            end else begin
              w_q[i] <= '0;
            end
          end
          state_q <= StAdd;
          idx_q   <= 3'd1;
        end
        StAdd: begin
          if (idx_q == 3'd1) begin
            w_q      <= wpad;
            v_q      <= h_q;
            rnd_q    <= '0;
            state_q  <= StRound;
            lenblk_q <= lenblk_q || fill_q < 6'd56;
            idx_q    <= '0;
          end else begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
            fill_q <= '0;
            if (final_q && lenblk_q) begin
              state_q <= StEmit;
            end else if (final_q) begin
              // a full data block still needs the marker, and a block with no room the length, in the next block
              lenblk_q <= (fill_q != 6'd0);
              for (int i = 0; i < 16; i++) w_q[i] <= '0;
              state_q <= StPad;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StRound: begin
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnext;
          rnd_q   <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= StAdd;
            idx_q   <= '0;
          end
        end
        StEmit: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q  <= StIdle;
              h_q      <= InitH;
              total_q  <= '0;
              fill_q   <= '0;
              final_q  <= 1'b0;
              lenblk_q <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(idx_q)))
    else $error("digest word moved while stalled");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_pop_o |-> state_q == StIdle) else $error("pop outside idle");
  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> total_q == '0)
    else $error("count not cleared after digest");
`endif

endmodule

>>> tb/sv/tb_sha256_stream_hasher.sv
`timescale 1ns / 100ps

class digest_scoreboard;
  logic [31:0] hash_st[8];
  logic [7:0]  blk[64];
  logic [63:0] byte_cnt;
  logic [31:0] exp_word[$];
  logic [2:0]  exp_num[$];
  logic        exp_last[$];
  int          fails;
  int          words_seen;
  int          msgs;

  function void restart();
    hash_st[0] = 32'h6a09e667; hash_st[1] = 32'hbb67ae85;
    hash_st[2] = 32'h3c6ef372; hash_st[3] = 32'ha54ff53a;
    hash_st[4] = 32'h510e527f; hash_st[5] = 32'h9b05688c;
    hash_st[6] = 32'h1f83d9ab; hash_st[7] = 32'h5be0cd19;
    byte_cnt = '0;
  endfunction

  function new();
    restart();
    fails = 0;
    words_seen = 0;
    msgs = 0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, e, a;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + sha_pkg::round_k(i[5:0]) + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  function void note_input(logic [7:0] d, logic has_b, logic eom);
    int fill;
    logic [63:0] bits;
    if (has_b) begin
      blk[byte_cnt[5:0]] = d;
      byte_cnt++;
      if (byte_cnt[5:0] == 6'd0) compress();
    end
    if (!eom) return;
    fill = int'(byte_cnt[5:0]);
    blk[fill++] = 8'h80;
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 8'h00;
      compress();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 8'h00;
    bits = byte_cnt << 3;
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(hash_st[i]);
      exp_num.push_back(i[2:0]);
      exp_last.push_back(i == 7);
    end
    msgs++;
    restart();
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fails++;
  endfunction

  function void check_word(logic [31:0] w, logic [2:0] n, logic l);
    words_seen++;
    if (exp_word.size() == 0) begin
      report("unexpected beat", w, 32'h0);
      return;
    end
    if (w !== exp_word[0]) report("digest_word", w, exp_word[0]);
    if (n !== exp_num[0]) report("word_number", 32'(n), 32'(exp_num[0]));
    if (l !== exp_last[0]) report("last_word", 32'(l), 32'(exp_last[0]));
    void'(exp_word.pop_front());
    void'(exp_num.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module tb_sha256_stream_hasher;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        last_word_o;

  digest_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  stim_done = 1'b0;
  int  beats_sent = 0;
  int  burst_left = 0;

  sha256_stream_hasher u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_input(data_byte_i, byte_present_i, end_of_message_i);
      if (out_valid_o && !out_stall_i)
        sb.check_word(digest_word_o, word_number_o, last_word_o);
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (($urandom_range(0, 999) / 250) == 0) out_stall_i <= ($urandom_range(0, 2) != 0);
    else out_stall_i <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("tb_sha256_stream_hasher: FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] d, logic has_b, logic eom);
    int gap;
    while (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    byte_present_i <= has_b;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_message(int len, bit bare_end, int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat($urandom, 1'b0, 1'b0);
      if (!bare_end && i == len - 1) send_beat($urandom, 1'b1, 1'b1);
      else send_beat($urandom, 1'b1, 1'b0);
    end
    if (bare_end || len == 0) send_beat($urandom, 1'b0, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty, bare beats, byte extremes, padding boundaries
    send_message(0, 1'b1, 0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b1, 1'b1);
    send_message(3, 1'b0, 0);
    send_message(5, 1'b1, 30);
    // boundary lengths around the length field and full blocks
    send_message(55, 1'b0, 0);
    send_message(56, 1'b1, 0);
    send_message(63, 1'b0, 0);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_message(64, 1'b0, 5);
    join
    send_message(64, 1'b1, 0);
    while (beats_sent < 340) begin
      case ($urandom_range(0, 9))
        0: send_message($urandom_range(0, 2), 1'b1, 20);
        1: send_message($urandom_range(55, 65), $urandom_range(0, 1), 5);
        2: send_message(100, 1'b0, 0);
        default: send_message($urandom_range(1, 20), $urandom_range(0, 1), 10);
      endcase
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.exp_word.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d input beats, %0d messages, %0d digest words checked",
             beats_sent, sb.msgs, sb.words_seen);
    $display("covered empty, padding-boundary, multi-block and back-pressure messages");
    if (sb.fails == 0 && sb.exp_word.size() == 0) begin
      $display("tb_sha256_stream_hasher: PASS");
    end else begin
      $display("tb_sha256_stream_hasher: FAIL");
    end
    $finish;
  end
endmodule
